>>> sv/ama_pkg.sv
// ----------------------------------------------------------------------------
// ama_pkg
// shared constants, register indexes and controller/datapath interface types
// for the adaptive moving average block
// ----------------------------------------------------------------------------
package ama_pkg;

    // window geometry
    localparam int MAX_ER_LEN = 31;
    localparam int MIN_ER_LEN = 2;
    localparam int WIN_DEPTH  = MAX_ER_LEN + 1;
    localparam int PTR_W      = $clog2(WIN_DEPTH);
    localparam int LEN_W      = $clog2(MAX_ER_LEN + 1);
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);

    // sample and average formats
    localparam int SAMPLE_W   = 32;
    localparam int GUARD_BITS = 16;
    localparam int AVG_W      = SAMPLE_W + GUARD_BITS;
    localparam int WORD_W     = SAMPLE_W + 1;

    // efficiency ratio and divider
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int VOL_W      = DIFF_W + $clog2(MAX_ER_LEN);
    localparam int REM_W      = VOL_W + 1;
    localparam int EFF_FRAC   = 16;
    localparam int EFF_W      = EFF_FRAC + 1;
    localparam int DIV_STEPS  = EFF_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // smoothing constant and average update
    localparam int COEFF_W    = 16;
    localparam int PROD_W     = EFF_W + COEFF_W + 2;
    localparam int SC_W       = 2 * COEFF_W;
    localparam int MAG_W      = AVG_W;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PP_W       = HALF_W + SC_W;
    localparam int FULL_W     = MAG_W + SC_W;

    // configuration port
    localparam int ER_W       = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = COEFF_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_ER_LENGTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_COEFF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_COEFF = 2'd2;

    localparam logic [ER_W-1:0]    ER_RESET   = 5'd10;
    localparam logic [COEFF_W-1:0] FAST_RESET = 16'd43691;
    localparam logic [COEFF_W-1:0] SLOW_RESET = 16'd4228;

    // commands from controller to datapath
    typedef struct packed {
        logic             accept;
        logic [PTR_W-1:0] wr_addr;
        logic             seed;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
        logic             acc_en;
        logic             acc_first;
        logic             div_load;
        logic             div_step;
        logic             smooth_mul;
        logic             smooth_add;
        logic             square;
        logic             mul_lo;
        logic             mul_hi;
        logic             sum;
        logic             update;
        logic             out_load;
    } ama_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic seeded;
    } ama_status_t;

endpackage

>>> sv/ama_dp.sv
// ----------------------------------------------------------------------------
// ama_dp
// datapath: sample window memory, volatility walk, restoring divider,
// smoothing constant, split multiply and average update
// ----------------------------------------------------------------------------
module ama_dp
    import ama_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ama_cmd_t            cmd,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                missing,
    input  logic [COEFF_W-1:0]  fast_coeff,
    input  logic [COEFF_W-1:0]  slow_coeff,
    output ama_status_t         status,
    output logic [SAMPLE_W-1:0] average,
    output logic                average_valid
);

    // window memory, entry = {missing, sample}
    logic [WORD_W-1:0] win_mem [WIN_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic [SAMPLE_W-1:0] x_reg;
    logic [SAMPLE_W-1:0] newest_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic                gap_reg;

    logic [REM_W-1:0]    rem_reg;
    logic [EFF_W-1:0]    quo_reg;
    logic                eff_zero_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic [COEFF_W-1:0]       smooth_reg;
    logic [SC_W-1:0]          sc_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [PP_W-1:0]          pp_lo_reg;
    logic [PP_W-1:0]          pp_hi_reg;
    logic [AVG_W-1:0]         step_reg;
    logic                     inexact_reg;

    logic [AVG_W-1:0]    avg_reg;
    logic                seeded_reg;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic                out_valid_reg;

    // combinational helpers
    logic signed [DIFF_W-1:0] nb_diff;
    logic [DIFF_W-1:0]        nb_abs;
    logic signed [DIFF_W-1:0] dir_diff;
    logic [DIFF_W-1:0]        dir_abs;
    logic                     div_ge;
    logic [REM_W-1:0]         div_rem;
    logic [EFF_W-1:0]         eff;
    logic signed [COEFF_W:0]  coeff_diff;
    logic signed [PROD_W-1:0] smooth_sum;
    logic signed [AVG_W:0]    avg_diff;
    logic [AVG_W:0]           avg_abs;
    logic [FULL_W-1:0]        full_prod;

    assign nb_diff  = $signed({prev_reg[SAMPLE_W-1], prev_reg})
                    - $signed({rd_data_reg[SAMPLE_W-1], rd_data_reg[SAMPLE_W-1:0]});
    assign nb_abs   = nb_diff[DIFF_W-1] ? DIFF_W'(-nb_diff) : DIFF_W'(nb_diff);
    assign dir_diff = $signed({newest_reg[SAMPLE_W-1], newest_reg})
                    - $signed({prev_reg[SAMPLE_W-1], prev_reg});
    assign dir_abs  = dir_diff[DIFF_W-1] ? DIFF_W'(-dir_diff) : DIFF_W'(dir_diff);

    assign div_ge  = rem_reg >= {1'b0, vol_reg};
    assign div_rem = div_ge ? rem_reg - {1'b0, vol_reg} : rem_reg;

    assign eff        = eff_zero_reg ? '0 : quo_reg;
    assign coeff_diff = $signed({1'b0, fast_coeff}) - $signed({1'b0, slow_coeff});
    assign smooth_sum = prod_reg
                      + $signed(PROD_W'({slow_coeff, {EFF_FRAC{1'b0}}}));

    assign avg_diff = $signed({x_reg[SAMPLE_W-1], x_reg, {GUARD_BITS{1'b0}}})
                    - $signed({avg_reg[AVG_W-1], avg_reg});
    assign avg_abs  = avg_diff[AVG_W] ? (AVG_W+1)'(-avg_diff) : (AVG_W+1)'(avg_diff);

    assign full_prod = {pp_hi_reg, {HALF_W{1'b0}}} + FULL_W'(pp_lo_reg);

    // window memory port
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            win_mem[cmd.wr_addr] <= {missing, sample};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= win_mem[cmd.rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= sample;
        end
        if (cmd.acc_en)
        begin
            prev_reg <= rd_data_reg[SAMPLE_W-1:0];
            if (cmd.acc_first)
            begin
                newest_reg <= rd_data_reg[SAMPLE_W-1:0];
                vol_reg    <= '0;
                gap_reg    <= rd_data_reg[WORD_W-1];
            end
            else
            begin
                vol_reg <= vol_reg + VOL_W'(nb_abs);
                gap_reg <= gap_reg | rd_data_reg[WORD_W-1];
            end
        end
        if (cmd.div_load)
        begin
            rem_reg      <= REM_W'(dir_abs);
            quo_reg      <= '0;
            eff_zero_reg <= gap_reg || (vol_reg == '0);
        end
        if (cmd.div_step)
        begin
            rem_reg <= {div_rem[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[EFF_W-2:0], div_ge};
        end
        if (cmd.smooth_mul)
        begin
            prod_reg <= $signed(PROD_W'({1'b0, eff})) * $signed(PROD_W'(coeff_diff));
        end
        if (cmd.smooth_add)
        begin
            smooth_reg <= smooth_sum[PROD_W-1] ? '0
                        : smooth_sum[EFF_FRAC+COEFF_W-1:EFF_FRAC];
        end
        if (cmd.square)
        begin
            sc_reg  <= smooth_reg * smooth_reg;
            neg_reg <= avg_diff[AVG_W];
            mag_reg <= avg_abs[MAG_W-1:0];
        end
        if (cmd.mul_lo)
        begin
            pp_lo_reg <= PP_W'(mag_reg[HALF_W-1:0]) * PP_W'(sc_reg);
        end
        if (cmd.mul_hi)
        begin
            pp_hi_reg <= PP_W'(mag_reg[MAG_W-1:HALF_W]) * PP_W'(sc_reg);
        end
        if (cmd.sum)
        begin
            step_reg    <= full_prod[FULL_W-1:SC_W];
            inexact_reg <= |full_prod[SC_W-1:0];
        end
        if (cmd.seed)
        begin
            avg_reg <= {sample, {GUARD_BITS{1'b0}}};
        end
        else if (cmd.update)
        begin
            // negative move rounds toward minus infinity
            if (neg_reg)
            begin
                avg_reg <= avg_reg - step_reg - AVG_W'(inexact_reg);
            end
            else
            begin
                avg_reg <= avg_reg + step_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_avg_reg <= seeded_reg ? avg_reg[AVG_W-1:GUARD_BITS] : '0;
        end
    end

    // control-like state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.seed)
            begin
                seeded_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= seeded_reg;
            end
        end
    end

    assign status.seeded = seeded_reg;
    assign average       = out_avg_reg;
    assign average_valid = out_valid_reg;

endmodule

>>> sv/ama_ctrl.sv
// ----------------------------------------------------------------------------
// ama_ctrl
// controller: window pointers, fill count, sequencing of the window walk,
// divider steps and average update, output handshake
// ----------------------------------------------------------------------------
module ama_ctrl
    import ama_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [ER_W-1:0] er_length,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            missing,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  ama_status_t     status,
    output ama_cmd_t        cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_WALK  = 12'b000000000010,
        S_DIVLD = 12'b000000000100,
        S_DIV   = 12'b000000001000,
        S_SMUL  = 12'b000000010000,
        S_SADD  = 12'b000000100000,
        S_SQ    = 12'b000001000000,
        S_MLO   = 12'b000010000000,
        S_MHI   = 12'b000100000000,
        S_SUM   = 12'b001000000000,
        S_UPD   = 12'b010000000000,
        S_FIN   = 12'b100000000000
    } ama_state_t;

    ama_state_t           state_reg,  state_next;
    logic [PTR_W-1:0]     wp_reg,     wp_next;
    logic [CNT_W-1:0]     fill_reg,   fill_next;
    logic [PTR_W-1:0]     item_reg,   item_next;
    logic [LEN_W-1:0]     len_reg,    len_next;
    logic [CNT_W-1:0]     walk_reg,   walk_next;
    logic [DIV_CNT_W-1:0] div_reg,    div_next;
    logic                 mvalid_reg, mvalid_next;

    logic                 accept;
    logic [LEN_W-1:0]     len_clamp;
    logic [CNT_W-1:0]     fill_inc;
    logic                 full;
    logic [PTR_W:0]       rd_sum;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        if (er_length < ER_W'(MIN_ER_LEN))
        begin
            len_clamp = LEN_W'(MIN_ER_LEN);
        end
        else if (er_length > ER_W'(MAX_ER_LEN))
        begin
            len_clamp = LEN_W'(MAX_ER_LEN);
        end
        else
        begin
            len_clamp = LEN_W'(er_length);
        end
    end

    assign fill_inc = (fill_reg < CNT_W'(WIN_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    assign full     = fill_inc >= (CNT_W'(len_clamp) + 1'b1);

    // k-th entry back from the newest one, modulo the window depth
    assign rd_sum = {1'b0, item_reg} + (PTR_W+1)'(WIN_DEPTH) - (PTR_W+1)'(walk_reg);

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        item_next   = item_reg;
        len_next    = len_reg;
        walk_next   = walk_reg;
        div_next    = div_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        s_tready    = (state_reg == S_IDLE);

        cmd.wr_addr   = wp_reg;
        cmd.rd_addr   = (rd_sum >= (PTR_W+1)'(WIN_DEPTH))
                      ? PTR_W'(rd_sum - (PTR_W+1)'(WIN_DEPTH)) : PTR_W'(rd_sum);
        cmd.acc_first = (walk_reg == CNT_W'(1));

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    item_next  = wp_reg;
                    wp_next    = (wp_reg == PTR_W'(WIN_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    fill_next  = fill_inc;
                    len_next   = len_clamp;
                    walk_next  = '0;
                    if (!missing && full && status.seeded)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        cmd.seed   = !missing && full;
                        state_next = S_FIN;
                    end
                end
            end
            S_WALK:
            begin
                cmd.rd_en  = (walk_reg <= CNT_W'(len_reg));
                cmd.acc_en = (walk_reg != '0);
                walk_next  = walk_reg + 1'b1;
                if (walk_reg == CNT_W'(len_reg) + 1'b1)
                begin
                    state_next = S_DIVLD;
                end
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                div_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_next     = div_reg + 1'b1;
                if (div_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                cmd.smooth_mul = 1'b1;
                state_next     = S_SADD;
            end
            S_SADD:
            begin
                cmd.smooth_add = 1'b1;
                state_next     = S_SQ;
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait for the output register to be free
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            item_reg   <= '0;
            len_reg    <= '0;
            walk_reg   <= '0;
            div_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            item_reg   <= item_next;
            len_reg    <= len_next;
            walk_reg   <= walk_next;
            div_reg    <= div_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!mvalid_reg || m_tready))
        else $error("result register overwritten while stalled");

    // fill count saturates at the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WIN_DEPTH))
        else $error("fill count beyond window depth");

    // an accepted transaction always leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("controller idle right after accepting a transaction");

    // the walk only starts on a window holding enough stored entries
    a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (fill_reg > CNT_W'(len_reg)))
        else $error("window walk on a window that is not full");

endmodule

>>> sv/adaptive_moving_average.sv
// ----------------------------------------------------------------------------
// adaptive_moving_average
// Kaufman adaptive moving average over signed Q16.16 samples, with missing
// sample markers, a configurable efficiency ratio length and Q0.16 constants
// ----------------------------------------------------------------------------
// update path: L = er_length clamped to 2..31 sets the length of the window walk;
//   missing samples, a window not yet full and the seeding sample skip the walk,
//   the divider and the update and pass straight on to the output register
// flow: a new transaction is taken only after the previous result is loaded into
//   the output register, which waits while an earlier result is unaccepted; update
//   time is set by the serial window walk and the 17-step restoring divider
// reset: asynchronous active low; control, seeded flag and config registers
//   return to defaults, the window memory is left as is and read only once written
// ----------------------------------------------------------------------------
module adaptive_moving_average
    import ama_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
    input  logic                  s_axis_tuser,   // [0] missing

    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [31:0] average
    output logic                  m_axis_tuser    // [0] average_valid
);

    logic [ER_W-1:0]    er_length_reg;
    logic [COEFF_W-1:0] fast_coeff_reg;
    logic [COEFF_W-1:0] slow_coeff_reg;

    ama_cmd_t    cmd;
    ama_status_t status;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            er_length_reg  <= ER_RESET;
            fast_coeff_reg <= FAST_RESET;
            slow_coeff_reg <= SLOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ER_LENGTH:
                begin
                    er_length_reg <= cfg_wdata[ER_W-1:0];
                end
                CFG_FAST_COEFF:
                begin
                    fast_coeff_reg <= cfg_wdata[COEFF_W-1:0];
                end
                CFG_SLOW_COEFF:
                begin
                    slow_coeff_reg <= cfg_wdata[COEFF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencing: pointers, fill count, walk and divider counters, handshakes
    ama_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .er_length (er_length_reg),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .missing   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // window memory, ratio divider, multipliers and the average register
    ama_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample        (s_axis_tdata),
        .missing       (s_axis_tuser),
        .fast_coeff    (fast_coeff_reg),
        .slow_coeff    (slow_coeff_reg),
        .status        (status),
        .average       (m_axis_tdata),
        .average_valid (m_axis_tuser)
    );

endmodule
